/* rtl/assert_macros.svh */
// Assertion macros used by the bus-over-SPI master core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, quiet in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, quiet in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wbspi_pkg.sv */
// Constants and codes for the bus-over-SPI byte master.
// No dependencies.
package wbspi_pkg;

    typedef enum logic [1:0] {
        OP_START_READ  = 2'd0,
        OP_START_WRITE = 2'd1,
        OP_EXCHANGE    = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_MARKER  = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    localparam logic [7:0] CMD_READ    = 8'h01;
    localparam logic [7:0] CMD_WRITE   = 8'h00;
    localparam logic [7:0] MARK_READ   = 8'h01;
    localparam logic [7:0] MARK_WRITE  = 8'h00;
    localparam logic [7:0] BUSY_BYTE   = 8'hFF;
    localparam logic [7:0] POLL_BYTE   = 8'h00;
    localparam logic [9:0] POLL_RESET  = 10'd256;
    localparam logic [3:0] READ_HDR    = 4'd5;
    localparam logic [3:0] WRITE_HDR   = 4'd9;
    localparam logic [3:0] DATA_BYTES  = 4'd4;

endpackage

/* rtl/wishbone_over_spi_master_core.sv */
// Bus-over-SPI byte master: one SPI byte exchange or request per transaction,
// one result per transaction. Depends on wbspi_pkg and assert_macros.svh.
//
// Takes one transaction per clock while the output is not stalled and delivers
// its result through an input register, then a result register; the loop is the
// phase state with its byte and poll counters. A start sends the command byte,
// then the address (and for a write the data word) big-endian, then 0x00 poll
// bytes while the target answers 0xFF, up to poll_limit of them (at least one);
// a read then collects four data bytes. A start while busy aborts silently.
// poll_limit may only be written while no transaction is in flight.
`include "assert_macros.svh"

module wishbone_over_spi_master_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        poll_limit_we,
    input  logic [9:0]  poll_limit_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[31:0], write_data[63:32], miso_byte[71:64]
    input  logic [71:0] s_tdata,
    // op[1:0]
    input  wbspi_pkg::op_t s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mosi_byte[7:0], select_active[8], status[10:9], read_data[42:11], zero[47:43]
    output logic [47:0] m_tdata,
    // send_byte[0], done_res[1]
    output logic [1:0]  m_tuser
);
    import wbspi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEND = 3'd1,
        PH_POLL = 3'd2,
        PH_DATA = 3'd3
    } phase_t;

    logic [9:0]  poll_limit_reg;
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [31:0] in_address_reg;
    logic [31:0] in_write_data_reg;
    logic [7:0]  in_miso_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [9:0]  poll_count_reg, poll_count_next;
    logic        is_write_reg, is_write_next;
    logic [31:0] held_address_reg, held_address_next;
    logic [31:0] held_write_data_reg, held_write_data_next;
    logic [31:0] read_shift_reg, read_shift_next;

    logic        out_valid_reg;
    logic [7:0]  mosi_byte_reg, mosi_byte_next;
    logic        send_byte_reg, send_byte_next;
    logic        select_active_reg, select_active_next;
    logic        done_res_reg, done_res_next;
    status_t     status_reg, status_next;
    logic [31:0] read_data_reg, read_data_next;

    logic        out_free;
    logic        fire;
    logic [9:0]  limit;
    logic [3:0]  index_inc;
    logic [9:0]  poll_inc;
    logic [31:0] shift_in;

    function automatic logic [7:0] header_byte(input logic [3:0] idx, input logic wr,
                                               input logic [31:0] addr,
                                               input logic [31:0] wdata);
        logic [7:0] b;
        case (idx)
            4'd0:    b = wr ? CMD_WRITE : CMD_READ;
            4'd1:    b = addr[31:24];
            4'd2:    b = addr[23:16];
            4'd3:    b = addr[15:8];
            4'd4:    b = addr[7:0];
            4'd5:    b = wdata[31:24];
            4'd6:    b = wdata[23:16];
            4'd7:    b = wdata[15:8];
            4'd8:    b = wdata[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign fire     = in_valid_reg && out_free;

    assign limit     = (poll_limit_reg == 10'd0) ? 10'd1 : poll_limit_reg;
    assign index_inc = byte_index_reg + 4'd1;
    assign poll_inc  = poll_count_reg + 10'd1;
    assign shift_in  = {read_shift_reg[23:0], in_miso_reg};

    always_comb begin
        phase_next           = phase_reg;
        byte_index_next      = byte_index_reg;
        poll_count_next      = poll_count_reg;
        is_write_next        = is_write_reg;
        held_address_next    = held_address_reg;
        held_write_data_next = held_write_data_reg;
        read_shift_next      = read_shift_reg;
        mosi_byte_next       = 8'h00;
        send_byte_next       = 1'b0;
        select_active_next   = 1'b0;
        done_res_next        = 1'b0;
        status_next          = ST_OK;
        read_data_next       = 32'd0;

        if (in_op_reg == OP_START_READ || in_op_reg == OP_START_WRITE) begin
            is_write_next        = (in_op_reg == OP_START_WRITE);
            held_address_next    = in_address_reg;
            held_write_data_next = in_write_data_reg;
            byte_index_next      = 4'd0;
            poll_count_next      = 10'd0;
            read_shift_next      = 32'd0;
            phase_next           = PH_SEND;
            mosi_byte_next       = (in_op_reg == OP_START_WRITE) ? CMD_WRITE : CMD_READ;
            send_byte_next       = 1'b1;
            select_active_next   = 1'b1;
        end else if (in_op_reg == OP_UNUSED || phase_reg == PH_IDLE) begin
            select_active_next = (phase_reg != PH_IDLE);
        end else begin
            case (phase_reg)
                PH_SEND: begin
                    send_byte_next     = 1'b1;
                    select_active_next = 1'b1;
                    if (index_inc < (is_write_reg ? WRITE_HDR : READ_HDR)) begin
                        byte_index_next = index_inc;
                        mosi_byte_next  = header_byte(index_inc, is_write_reg,
                                                      held_address_reg, held_write_data_reg);
                    end else begin
                        phase_next      = PH_POLL;
                        poll_count_next = 10'd0;
                        byte_index_next = 4'd0;
                        mosi_byte_next  = POLL_BYTE;
                    end
                end
                PH_POLL: begin
                    poll_count_next = poll_inc;
                    if (in_miso_reg != BUSY_BYTE) begin
                        if (!is_write_reg && in_miso_reg == MARK_READ) begin
                            phase_next         = PH_DATA;
                            byte_index_next    = 4'd0;
                            read_shift_next    = 32'd0;
                            mosi_byte_next     = POLL_BYTE;
                            send_byte_next     = 1'b1;
                            select_active_next = 1'b1;
                        end else begin
                            phase_next    = PH_IDLE;
                            done_res_next = 1'b1;
                            status_next   = (is_write_reg && in_miso_reg == MARK_WRITE)
                                            ? ST_OK : ST_MARKER;
                        end
                    end else if (poll_inc >= limit) begin
                        phase_next    = PH_IDLE;
                        done_res_next = 1'b1;
                        status_next   = ST_TIMEOUT;
                    end else begin
                        mosi_byte_next     = POLL_BYTE;
                        send_byte_next     = 1'b1;
                        select_active_next = 1'b1;
                    end
                end
                PH_DATA: begin
                    read_shift_next = shift_in;
                    if (index_inc >= DATA_BYTES) begin
                        phase_next      = PH_IDLE;
                        byte_index_next = 4'd0;
                        done_res_next   = 1'b1;
                        read_data_next  = shift_in;
                    end else begin
                        byte_index_next    = index_inc;
                        mosi_byte_next     = POLL_BYTE;
                        send_byte_next     = 1'b1;
                        select_active_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg      <= POLL_RESET;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            in_op_reg           <= OP_UNUSED;
            in_address_reg      <= 32'd0;
            in_write_data_reg   <= 32'd0;
            in_miso_reg         <= 8'h00;
            phase_reg           <= PH_IDLE;
            byte_index_reg      <= 4'd0;
            poll_count_reg      <= 10'd0;
            is_write_reg        <= 1'b0;
            held_address_reg    <= 32'd0;
            held_write_data_reg <= 32'd0;
            read_shift_reg      <= 32'd0;
            mosi_byte_reg       <= 8'h00;
            send_byte_reg       <= 1'b0;
            select_active_reg   <= 1'b0;
            done_res_reg        <= 1'b0;
            status_reg          <= ST_OK;
            read_data_reg       <= 32'd0;
        end else begin
            if (poll_limit_we) begin
                poll_limit_reg <= poll_limit_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (s_tready && s_tvalid) begin
                in_op_reg         <= s_tuser;
                in_address_reg    <= s_tdata[31:0];
                in_write_data_reg <= s_tdata[63:32];
                in_miso_reg       <= s_tdata[71:64];
            end
            if (fire) begin
                phase_reg           <= phase_next;
                byte_index_reg      <= byte_index_next;
                poll_count_reg      <= poll_count_next;
                is_write_reg        <= is_write_next;
                held_address_reg    <= held_address_next;
                held_write_data_reg <= held_write_data_next;
                read_shift_reg      <= read_shift_next;
                mosi_byte_reg       <= mosi_byte_next;
                send_byte_reg       <= send_byte_next;
                select_active_reg   <= select_active_next;
                done_res_reg        <= done_res_next;
                status_reg          <= status_next;
                read_data_reg       <= read_data_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, read_data_reg, status_reg, select_active_reg, mosi_byte_reg};
    assign m_tuser  = {done_res_reg, send_byte_reg};

    `ASSERT_SAME(a_done_releases, out_valid_reg && done_res_reg,
                 !send_byte_reg && !select_active_reg, "done result still drives the link")
    `ASSERT_SAME(a_status_on_done, out_valid_reg && status_reg != ST_OK, done_res_reg,
                 "error status without done")
    `ASSERT_NEXT(a_done_to_idle, fire && done_res_next, phase_reg == PH_IDLE,
                 "phase not idle after done")
    `ASSERT_SAME(a_send_index, phase_reg == PH_SEND, byte_index_reg < WRITE_HDR,
                 "header index out of range")

endmodule
